@@ hw/rtl/cht_pkg.sv @@
// package for the chained hash table: sizes, command and status codes
// no dependencies
package cht_pkg;
    localparam int BUCKETS = 16;
    localparam int NODES = 64;
    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int PW = NW + 1;
    localparam int KW = 31;
    localparam int VW = 32;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_MISS = 2'd1,
        ST_NEW  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    // one node write request from the sequencer to the node store
    typedef struct packed {
        logic          we_key;
        logic          we_val;
        logic          we_next;
        logic [NW-1:0] addr;
        logic [KW-1:0] key;
        logic [VW-1:0] val;
        logic [PW-1:0] next;
    } t_node_wr;
endpackage

@@ hw/rtl/cht_node_mem.sv @@
// node store of the chained hash table: key, value and next memories
// depends on cht_pkg
module cht_node_mem (
    input  logic               i_clk,
    input  logic               i_rd,
    input  logic [cht_pkg::NW-1:0] i_rd_addr,
    input  cht_pkg::t_node_wr  i_wr,
    output logic [cht_pkg::KW-1:0] o_key,
    output logic [cht_pkg::VW-1:0] o_val,
    output logic [cht_pkg::PW-1:0] o_next
);
    import cht_pkg::*;

    logic [KW-1:0] r_key_mem  [NODES];
    logic [VW-1:0] r_val_mem  [NODES];
    logic [PW-1:0] r_next_mem [NODES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we_key) r_key_mem[i_wr.addr] <= i_wr.key;
        if (i_wr.we_val) r_val_mem[i_wr.addr] <= i_wr.val;
        if (i_wr.we_next) r_next_mem[i_wr.addr] <= i_wr.next;
        if (i_rd) begin
            o_key  <= r_key_mem[i_rd_addr];
            o_val  <= r_val_mem[i_rd_addr];
            o_next <= r_next_mem[i_rd_addr];
        end
    end
endmodule

@@ hw/rtl/chained_hash_table.sv @@
// top level of the chained hash table: request sequencer, bucket heads, free stack
// depends on cht_pkg and cht_node_mem
//
// a key-value table with separate chaining over a pool of NODES nodes. each
// slave transaction carries one request (lookup, insert-or-update, remove) and
// gives exactly one master transaction. the bucket is the low bits of the key.
// one request at a time: an accept state, then a head state that fetches the bucket
// head, then a read state (synchronous node memory read) and a compare state for
// each chain node visited, a pop state on a miss that takes a free node for an
// insert, and a done state that hands the result over; the unused command goes
// from accept straight to done. the chain walk goes through the single read port
// of the node store. bucket heads are flip-flops with valid bits; the free stack
// is a memory initialised by a clearing pass over all NODES entries after reset,
// during which no request is accepted. a result waits in an output register, and
// the next request is taken as soon as that register is handed over.
module chained_hash_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], key[32:2], value_in[64:33], zero fill to 72 bits
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: value_out[31:0], status[33:32], zero fill to 40 bits
    output logic [39:0] m_axis_tdata
);
    import cht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_READ, S_CMP, S_POP, S_DONE
    } t_state;

    t_state        r_state;
    logic [NW:0]   r_clr;
    logic [1:0]    r_cmd;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [PW-1:0] r_cur, r_prev;
    logic [NW:0]   r_steps;
    logic [PW-1:0] r_free_count;
    logic [PW-1:0] r_head [BUCKETS];
    logic          r_head_v [BUCKETS];
    logic [NW-1:0] r_fs_mem [NODES];
    logic [NW-1:0] r_fs_q;
    logic          r_ovalid;
    logic [VW-1:0] r_ovalue;
    logic [1:0]    r_ostatus;
    // linking the new node at the tail uses a second write, done in S_DONE
    logic          r_link;

    logic [KW-1:0] w_nkey;
    logic [VW-1:0] w_nval;
    logic [PW-1:0] w_nnext;
    logic          w_rd;
    t_node_wr      w_wr;
    logic [BW-1:0] w_bkt;
    logic [PW-1:0] w_head;

    assign w_bkt = r_key[BW-1:0];
    assign w_head = r_head_v[w_bkt] ? r_head[w_bkt] : NIL;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_ostatus, r_ovalue};
    assign w_rd = (r_state == S_READ);

    cht_node_mem u_nodes (
        .i_clk     (i_clk),
        .i_rd      (w_rd),
        .i_rd_addr (r_cur[NW-1:0]),
        .i_wr      (w_wr),
        .o_key     (w_nkey),
        .o_val     (w_nval),
        .o_next    (w_nnext)
    );

    // node writes happen only in the compare, pop and done states
    always_comb begin
        w_wr = '0;
        w_wr.key = r_key;
        w_wr.val = r_val;
        w_wr.next = NIL;
        w_wr.addr = r_cur[NW-1:0];
        if (r_state == S_CMP && w_nkey == r_key && r_steps < (NW+1)'(NODES)) begin
            if (r_cmd == CMD_INSERT) w_wr.we_val = 1'b1;
            if (r_cmd == CMD_REMOVE && r_prev != NIL) begin
                w_wr.we_next = 1'b1;
                w_wr.addr = r_prev[NW-1:0];
                w_wr.next = w_nnext;
            end
        end
        // new node only on an insert miss with a free node left
        if (r_state == S_POP && r_cmd == CMD_INSERT && r_free_count != '0) begin
            w_wr.addr = r_fs_q;
            w_wr.we_key = 1'b1;
            w_wr.we_val = 1'b1;
            w_wr.we_next = 1'b1;
        end
        // tail of the chain now points at the new node
        if (r_state == S_DONE && r_link) begin
            w_wr.we_next = 1'b1;
            w_wr.addr = r_prev[NW-1:0];
            w_wr.next = r_cur;
        end
    end

    // free stack memory: clearing pass, push on remove, pop read at insert miss
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR)
            r_fs_mem[r_clr[NW-1:0]] <= NW'(NODES - 1) - r_clr[NW-1:0];
        else if (r_state == S_CMP && r_cmd == CMD_REMOVE && w_nkey == r_key
                 && r_steps < (NW+1)'(NODES) && r_free_count < NIL)
            r_fs_mem[r_free_count[NW-1:0]] <= r_cur[NW-1:0];
        r_fs_q <= r_fs_mem[NW'(r_free_count - PW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_free_count <= NIL;
            r_link <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) r_head_v[i] <= 1'b0;
        end else begin
            if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (NW+1)'(NODES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd <= s_axis_tdata[1:0];
                        r_key <= s_axis_tdata[32:2];
                        r_val <= s_axis_tdata[64:33];
                        r_ovalue <= '0;
                        r_ostatus <= ST_MISS;
                        r_state <= (s_axis_tdata[1:0] == CMD_NONE) ? S_DONE : S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_cur <= w_head;
                    r_prev <= NIL;
                    r_steps <= '0;
                    r_state <= (w_head == NIL) ? S_POP : S_READ;
                end
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    if (w_nkey == r_key && r_steps < (NW+1)'(NODES)) begin
                        r_ostatus <= ST_HIT;
                        if (r_cmd == CMD_LOOKUP) r_ovalue <= w_nval;
                        if (r_cmd == CMD_REMOVE) begin
                            if (r_prev == NIL) begin
                                r_head[w_bkt] <= w_nnext;
                                r_head_v[w_bkt] <= 1'b1;
                            end
                            if (r_free_count < NIL) r_free_count <= r_free_count + 1'b1;
                        end
                        r_state <= S_DONE;
                    end else if (w_nnext >= NIL || r_steps == (NW+1)'(NODES - 1)) begin
                        r_prev <= r_cur;
                        r_state <= S_POP;
                    end else begin
                        r_prev <= r_cur;
                        r_cur <= w_nnext;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_POP: begin
                    // r_fs_q holds the stack top, read in the previous cycle
                    if (r_cmd == CMD_INSERT) begin
                        if (r_free_count == '0) begin
                            r_ostatus <= ST_FULL;
                        end else begin
                            r_ostatus <= ST_NEW;
                            r_free_count <= r_free_count - 1'b1;
                            r_cur <= {1'b0, r_fs_q};
                            if (r_prev == NIL) begin
                                r_head[w_bkt] <= {1'b0, r_fs_q};
                                r_head_v[w_bkt] <= 1'b1;
                            end else r_link <= 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_link <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule

@@ hw/rtl/chained_hash_table_chk.sv @@
// port checker for the chained hash table, bound to the top level
// depends on cht_pkg and the top-level ports
module chained_hash_table_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    import cht_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33:32] != ST_HIT |-> m_axis_tdata[31:0] == 32'd0)
        else $error("value on non-hit");
endmodule

bind chained_hash_table chained_hash_table_chk u_chk (.*);
